/* rtl/core/brt_pkg.sv */
// Package for the binary trie route table.
// Holds payload structs, command and status codes, fixed widths and request structs.
// Used by every module of the block.
package brt_pkg;

  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned HOP_BITS   = 8;
  localparam int unsigned NODES_DEF  = 256;
  localparam int unsigned LEN_MAX    = ADDR_BITS;
  localparam int unsigned DEPTH_W    = $clog2(LEN_MAX + 1);
  localparam int unsigned PATH_DEPTH = LEN_MAX + 1;
  localparam int unsigned BIT_IDX_W  = $clog2(ADDR_BITS);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_PATH = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ADDR_BITS-1:0] prefix_bits;
    logic [4:0]           prefix_len;
    logic [HOP_BITS-1:0]  hop_value;
  } in_item_t;

  typedef struct packed {
    logic [HOP_BITS-1:0] hop_out;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } nm_req_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fs_req_t;

endpackage

/* rtl/core/brt_node_mem.sv */
// Node pool memory: hop and both child links per node, with a registered read.
// The root entry lives in flip-flops so it resets to empty; the pool needs no reset.
// Depends on brt_pkg.
module brt_node_mem #(
  parameter int unsigned NODES = brt_pkg::NODES_DEF,
  parameter int unsigned NW    = $clog2(NODES),
  parameter int unsigned EW    = brt_pkg::HOP_BITS + 2 * NW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  brt_pkg::nm_req_t req_i,
  input  logic [NW-1:0]    rd_addr_i,
  input  logic [NW-1:0]    wr_addr_i,
  input  logic [EW-1:0]    wr_data_i,
  output logic [EW-1:0]    rd_data_o
);

  logic [EW-1:0] mem [NODES];
  logic [EW-1:0] root_q;
  logic [EW-1:0] rdata_q;
  logic          rsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      rsel_q <= 1'b0;
    end else begin
      if (req_i.wr && wr_addr_i == '0) begin
        root_q <= wr_data_i;
      end
      if (req_i.rd) begin
        rsel_q <= (rd_addr_i == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (req_i.rd) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rsel_q ? root_q : rdata_q;

endmodule

/* rtl/core/brt_free_stack.sv */
// Free node stack: memory of node indices with a fill count and a low-water mark.
// Entries never written since reset read as their reset index. Depends on brt_pkg.
module brt_free_stack #(
  parameter int unsigned NODES = brt_pkg::NODES_DEF,
  parameter int unsigned NW    = $clog2(NODES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  brt_pkg::fs_req_t req_i,
  input  logic [NW-1:0]    push_data_i,
  output logic [NW-1:0]    pop_data_o,
  output logic [NW-1:0]    count_o
);

  logic [NW-1:0] mem [NODES];
  logic [NW-1:0] count_q;
  logic [NW-1:0] low_q;
  logic [NW-1:0] rdata_q;
  logic [NW-1:0] init_q;
  logic          use_mem_q;
  logic [NW-1:0] top_idx;

  assign top_idx = count_q - NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= NW'(NODES - 1);
      low_q     <= NW'(NODES - 1);
      use_mem_q <= 1'b0;
    end else if (req_i.pop) begin
      count_q   <= top_idx;
      use_mem_q <= (count_q > low_q);
      if (top_idx < low_q) begin
        low_q <= top_idx;
      end
    end else if (req_i.push) begin
      count_q <= count_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[count_q] <= push_data_i;
    end
    if (req_i.pop) begin
      rdata_q <= mem[top_idx];
      init_q  <= NW'(NODES - 1) - top_idx;
    end
  end

  assign pop_data_o = use_mem_q ? rdata_q : init_q;
  assign count_o    = count_q;

endmodule

/* rtl/core/brt_ctrl.sv */
// Command sequencer: walks the trie, allocates on insert, prunes on remove.
// Drives the node memory and free stack; holds the path stack and result register.
// Depends on brt_pkg.
module brt_ctrl #(
  parameter int unsigned NODES = brt_pkg::NODES_DEF,
  parameter int unsigned NW    = $clog2(NODES),
  parameter int unsigned EW    = brt_pkg::HOP_BITS + 2 * NW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brt_pkg::out_item_t out_data_o,
  output brt_pkg::nm_req_t   nm_req_o,
  output logic [NW-1:0]      nm_rd_addr_o,
  output logic [NW-1:0]      nm_wr_addr_o,
  output logic [EW-1:0]      nm_wr_data_o,
  input  logic [EW-1:0]      nm_rd_data_i,
  output brt_pkg::fs_req_t   fs_req_o,
  output logic [NW-1:0]      fs_push_data_o,
  input  logic [NW-1:0]      fs_pop_data_i,
  input  logic [NW-1:0]      fs_count_i
);

  localparam int unsigned HB = brt_pkg::HOP_BITS;
  localparam int unsigned DW = brt_pkg::DEPTH_W;
  localparam int unsigned AB = brt_pkg::ADDR_BITS;
  localparam int unsigned BW = brt_pkg::BIT_IDX_W;
  localparam int unsigned CW = (DW > NW) ? DW + 1 : NW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_AL_POP, S_AL_LINK, S_FIN, S_UN_RD, S_UN_WR, S_DONE
  } state_e;

  state_e                 state_q;
  brt_pkg::cmd_e          cmd_q;
  logic [AB-1:0]          rev_q;
  logic [DW-1:0]          len_q;
  logic [HB-1:0]          hop_q;
  logic [DW-1:0]          d_q;
  logic [NW-1:0]          cur_q;
  logic [EW-1:0]          ent_q;
  logic [HB-1:0]          best_q;
  brt_pkg::status_e       stat_q;
  logic [NW-1:0]          rel_q;
  logic [NW-1:0]          par_q;
  logic [NW-1:0]          path_q [brt_pkg::PATH_DEPTH];
  brt_pkg::out_item_t     out_q;
  logic                   out_valid_q;

  logic [AB-1:0] rev_in;
  logic [DW-1:0] len_in;
  logic [HB-1:0] e_hop;
  logic [NW-1:0] e_c1, e_c0;
  logic [DW-1:0] d_m1;
  logic          bit_cur, bit_up;
  logic [NW-1:0] nxt;
  logic          nxt_ok, at_end, no_room, leaf, up_prune;
  logic [EW-1:0] link_ent, clr_ent;

  function automatic logic child_ok(logic [NW-1:0] c);
    return (c != '0) && (32'(c) < NODES);
  endfunction

  always_comb begin
    for (int k = 0; k < AB; k++) begin
      rev_in[k] = in_data_i.prefix_bits[AB-1-k];
    end
  end

  assign len_in   = (in_data_i.prefix_len > 5'(AB)) ? DW'(AB) : DW'(in_data_i.prefix_len);
  assign e_hop    = nm_rd_data_i[EW-1 -: HB];
  assign e_c1     = nm_rd_data_i[2*NW-1 -: NW];
  assign e_c0     = nm_rd_data_i[NW-1:0];
  assign d_m1     = d_q - DW'(1);
  assign bit_cur  = rev_q[d_q[BW-1:0]];
  assign bit_up   = rev_q[d_m1[BW-1:0]];
  assign nxt      = bit_cur ? e_c1 : e_c0;
  assign nxt_ok   = child_ok(nxt);
  assign at_end   = (d_q == len_q);
  assign no_room  = CW'(len_q - d_q) > CW'(fs_count_i);
  assign leaf     = !child_ok(e_c0) && !child_ok(e_c1);
  assign link_ent = bit_cur ? {ent_q[EW-1 -: HB], fs_pop_data_i, ent_q[NW-1:0]}
                            : {ent_q[EW-1 -: NW+HB], fs_pop_data_i};
  assign clr_ent  = bit_up ? {e_hop, {NW{1'b0}}, e_c0} : {e_hop, e_c1, {NW{1'b0}}};
  assign up_prune = (par_q != '0) && (e_hop == '0)
                    && !(bit_up ? child_ok(e_c0) : child_ok(e_c1));

  always_comb begin
    nm_req_o       = '0;
    nm_rd_addr_o   = '0;
    nm_wr_addr_o   = cur_q;
    nm_wr_data_o   = {hop_q, nm_rd_data_i[2*NW-1:0]};
    fs_req_o       = '0;
    fs_push_data_o = rel_q;
    case (state_q)
      S_IDLE: begin
        nm_req_o.rd = in_valid_i && (in_data_i.cmd != brt_pkg::CMD_NONE);
      end
      S_WALK: begin
        if (at_end) begin
          nm_req_o.wr = (cmd_q == brt_pkg::CMD_INSERT) || (cmd_q == brt_pkg::CMD_REMOVE);
          if (cmd_q == brt_pkg::CMD_REMOVE) begin
            nm_wr_data_o = {{HB{1'b0}}, nm_rd_data_i[2*NW-1:0]};
          end
        end else if (nxt_ok) begin
          nm_req_o.rd  = 1'b1;
          nm_rd_addr_o = nxt;
        end
      end
      S_AL_POP: begin
        fs_req_o.pop = 1'b1;
      end
      S_AL_LINK: begin
        nm_req_o.wr  = 1'b1;
        nm_wr_data_o = link_ent;
      end
      S_FIN: begin
        nm_req_o.wr  = 1'b1;
        nm_wr_data_o = {hop_q, ent_q[2*NW-1:0]};
      end
      S_UN_RD: begin
        nm_req_o.rd  = 1'b1;
        nm_rd_addr_o = path_q[d_m1];
      end
      S_UN_WR: begin
        nm_req_o.wr   = 1'b1;
        nm_wr_addr_o  = par_q;
        nm_wr_data_o  = clr_ent;
        fs_req_o.push = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (in_data_i.cmd == brt_pkg::CMD_NONE) ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          if (at_end) begin
            if (cmd_q == brt_pkg::CMD_REMOVE && cur_q != '0 && leaf) begin
              state_q <= S_UN_RD;
            end else begin
              state_q <= S_DONE;
            end
          end else if (!nxt_ok) begin
            state_q <= (cmd_q == brt_pkg::CMD_INSERT && !no_room) ? S_AL_POP : S_DONE;
          end
        end
        S_AL_POP: state_q <= S_AL_LINK;
        S_AL_LINK: state_q <= (d_q + DW'(1) == len_q) ? S_FIN : S_AL_POP;
        S_FIN: state_q <= S_DONE;
        S_UN_RD: state_q <= S_UN_WR;
        S_UN_WR: state_q <= (up_prune && d_m1 != '0) ? S_UN_RD : S_DONE;
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            out_q.hop_out <= (cmd_q == brt_pkg::CMD_LOOKUP) ? best_q : '0;
            out_q.status  <= stat_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q  <= brt_pkg::cmd_e'(in_data_i.cmd);
        rev_q  <= rev_in;
        len_q  <= len_in;
        hop_q  <= in_data_i.hop_value;
        d_q    <= '0;
        cur_q  <= '0;
        best_q <= '0;
        stat_q <= brt_pkg::ST_DONE;
      end
      S_WALK: begin
        path_q[d_q] <= cur_q;
        ent_q       <= nm_rd_data_i;
        rel_q       <= cur_q;
        if (e_hop != '0) begin
          best_q <= e_hop;
        end
        if (!at_end) begin
          if (nxt_ok) begin
            cur_q <= nxt;
            d_q   <= d_q + DW'(1);
          end else if (cmd_q == brt_pkg::CMD_REMOVE) begin
            stat_q <= brt_pkg::ST_NO_PATH;
          end else if (cmd_q == brt_pkg::CMD_INSERT && no_room) begin
            stat_q <= brt_pkg::ST_FULL;
          end
        end
      end
      S_AL_LINK: begin
        cur_q <= fs_pop_data_i;
        ent_q <= '0;
        d_q   <= d_q + DW'(1);
      end
      S_UN_RD: begin
        par_q <= path_q[d_m1];
      end
      S_UN_WR: begin
        rel_q <= par_q;
        d_q   <= d_m1;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/binary_trie_route_table.sv */
// Binary trie route table with longest prefix match, top level.
// Instantiates brt_ctrl, brt_node_mem and brt_free_stack; depends on brt_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one command per
//   transfer: insert a prefix with its hop, remove a prefix, or look up an address.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns one result per
//   command: the hop for a lookup (0 when nothing matches) and a status code.
//   One command is in work at a time; the next can be taken in the same cycle that the
//   result first shows in the output register, even while it waits on a stalled receiver.
//   Work per command, one node access per trie level:
//     lookup:  walk down until len or a missing child
//     insert:  walk the existing path, then a free-stack pop and a link write per new node
//     remove:  walk down to len, then a parent read and a parent write per pruned node
//   A stalled receiver holds the result; the next command then waits in its final step.
//   Reset empties the trie (root only, no hop) and refills the free node stack;
//   no clearing pass is needed, so commands are taken right after reset.
module binary_trie_route_table #(
  parameter int unsigned NODES = brt_pkg::NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brt_pkg::out_item_t out_data_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned EW = brt_pkg::HOP_BITS + 2 * NW;

  brt_pkg::nm_req_t nm_req;
  logic [NW-1:0]    nm_rd_addr, nm_wr_addr;
  logic [EW-1:0]    nm_wr_data, nm_rd_data;
  brt_pkg::fs_req_t fs_req;
  logic [NW-1:0]    fs_push_data, fs_pop_data, fs_count;

  brt_ctrl #(.NODES(NODES), .NW(NW), .EW(EW)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o),
    .nm_req_o       (nm_req),
    .nm_rd_addr_o   (nm_rd_addr),
    .nm_wr_addr_o   (nm_wr_addr),
    .nm_wr_data_o   (nm_wr_data),
    .nm_rd_data_i   (nm_rd_data),
    .fs_req_o       (fs_req),
    .fs_push_data_o (fs_push_data),
    .fs_pop_data_i  (fs_pop_data),
    .fs_count_i     (fs_count)
  );

  brt_node_mem #(.NODES(NODES), .NW(NW), .EW(EW)) u_node_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (nm_req),
    .rd_addr_i (nm_rd_addr),
    .wr_addr_i (nm_wr_addr),
    .wr_data_i (nm_wr_data),
    .rd_data_o (nm_rd_data)
  );

  brt_free_stack #(.NODES(NODES), .NW(NW)) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (fs_req),
    .push_data_i (fs_push_data),
    .pop_data_o  (fs_pop_data),
    .count_o     (fs_count)
  );

`ifndef SYNTHESIS
  a_pop_push_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fs_req.pop && fs_req.push))
    else $error("free stack pop and push in one cycle");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_req.pop |-> fs_count != '0)
    else $error("pop from empty free stack");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(nm_req.rd && nm_req.wr && nm_rd_addr == nm_wr_addr))
    else $error("node read and write to one entry in one cycle");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transfer taken while a command is in work");
`endif

endmodule

/* test/tb.sv */
// Testbench for binary_trie_route_table: drives insert, remove and lookup commands.
// Checks every result against a behavioral trie with a free node stack, or against the table value for typed rows.
// Depends on brt_pkg and the RTL of the route table.
`timescale 1ns / 100ps

module tb;

  localparam int NNODES = 256;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  brt_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  brt_pkg::out_item_t out_data_o;

  binary_trie_route_table u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]  trie_hop [NNODES];
  logic [7:0]  trie_kid [NNODES][2];
  logic [7:0]  pool [NNODES];
  int          pool_cnt;
  brt_pkg::out_item_t pending_results[$];
  int          errors = 0;
  int          n_ins = 0, n_rem = 0, n_look = 0, n_full = 0, n_nopath = 0;
  bit          stim_done = 0;
  int          idle_cycles = 0;

  function automatic bit bit_of(logic [15:0] bits, int d);
    return bits[15 - d];
  endfunction

  function automatic void trie_reset();
    for (int k = 0; k < NNODES; k++) begin
      trie_hop[k] = '0;
      trie_kid[k][0] = '0;
      trie_kid[k][1] = '0;
    end
    for (int k = 0; k < NNODES - 1; k++) pool[k] = 8'(NNODES - 1 - k);
    pool_cnt = NNODES - 1;
  endfunction

  function automatic brt_pkg::out_item_t route_predict(brt_pkg::in_item_t it);
    brt_pkg::out_item_t r;
    int len, cur, d, nxt, par;
    int path [17];
    bit prune;
    r = '0;
    len = (it.prefix_len > 5'd16) ? 16 : int'(it.prefix_len);
    cur = 0;
    case (brt_pkg::cmd_e'(it.cmd))
      brt_pkg::CMD_INSERT: begin
        d = 0;
        while (d < len && trie_kid[cur][bit_of(it.prefix_bits, d)] != 0) begin
          cur = int'(trie_kid[cur][bit_of(it.prefix_bits, d)]);
          d++;
        end
        if (len - d > pool_cnt) begin
          r.status = brt_pkg::ST_FULL;
        end else begin
          while (d < len) begin
            pool_cnt--;
            nxt = int'(pool[pool_cnt]);
            trie_hop[nxt] = '0;
            trie_kid[nxt][0] = '0;
            trie_kid[nxt][1] = '0;
            trie_kid[cur][bit_of(it.prefix_bits, d)] = 8'(nxt);
            cur = nxt;
            d++;
          end
          trie_hop[cur] = it.hop_value;
        end
      end
      brt_pkg::CMD_REMOVE: begin
        r.status = brt_pkg::ST_DONE;
        for (d = 0; d < len; d++) begin
          path[d] = cur;
          nxt = int'(trie_kid[cur][bit_of(it.prefix_bits, d)]);
          if (nxt == 0) begin
            r.status = brt_pkg::ST_NO_PATH;
            break;
          end
          cur = nxt;
        end
        if (r.status == brt_pkg::ST_DONE) begin
          path[len] = cur;
          trie_hop[cur] = '0;
          prune = cur != 0 && trie_kid[cur][0] == 0 && trie_kid[cur][1] == 0;
          d = len;
          while (prune && d > 0) begin
            d--;
            par = path[d];
            trie_hop[path[d+1]] = '0;
            trie_kid[path[d+1]][0] = '0;
            trie_kid[path[d+1]][1] = '0;
            pool[pool_cnt] = 8'(path[d+1]);
            pool_cnt++;
            trie_kid[par][bit_of(it.prefix_bits, d)] = '0;
            prune = par != 0 && trie_hop[par] == 0 &&
                    trie_kid[par][0] == 0 && trie_kid[par][1] == 0;
          end
        end
      end
      brt_pkg::CMD_LOOKUP: begin
        r.hop_out = trie_hop[0];
        for (d = 0; d < len; d++) begin
          cur = int'(trie_kid[cur][bit_of(it.prefix_bits, d)]);
          if (cur == 0) break;
          if (trie_hop[cur] != 0) r.hop_out = trie_hop[cur];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  typedef struct {
    brt_pkg::in_item_t  item;
    bit                 typed;
    brt_pkg::out_item_t want;
  } row_t;

  row_t directed[$];

  function automatic brt_pkg::in_item_t mk(brt_pkg::cmd_e c, logic [15:0] b,
                                           logic [4:0] l, logic [7:0] h);
    brt_pkg::in_item_t it;
    it.cmd = c;
    it.prefix_bits = b;
    it.prefix_len = l;
    it.hop_value = h;
    return it;
  endfunction

  function automatic void add_row(brt_pkg::in_item_t it, bit typed, logic [7:0] h,
                                  brt_pkg::status_e s);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.want.hop_out = h;
    r.want.status = s;
    directed.push_back(r);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(brt_pkg::in_item_t it, bit typed, brt_pkg::out_item_t want);
    brt_pkg::out_item_t pred;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = route_predict(it);
    if (typed && pred != want)
      $display("tb: table row disagrees with predictor for cmd %0d", it.cmd);
    pending_results.push_back(typed ? want : pred);
    case (brt_pkg::cmd_e'(it.cmd))
      brt_pkg::CMD_INSERT: n_ins++;
      brt_pkg::CMD_REMOVE: n_rem++;
      brt_pkg::CMD_LOOKUP: n_look++;
      default: ;
    endcase
    if (pred.status == brt_pkg::ST_FULL) n_full++;
    if (pred.status == brt_pkg::ST_NO_PATH) n_nopath++;
  endtask

  function automatic brt_pkg::in_item_t rand_item(int mode);
    brt_pkg::in_item_t it;
    int p;
    it.prefix_bits = 16'($urandom());
    it.prefix_len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(0, 16));
    if (mode == 1) it.prefix_bits = {3'($urandom_range(0, 7)), 13'($urandom())};
    it.hop_value = 8'($urandom());
    p = $urandom_range(0, 99);
    if (p < 40) it.cmd = brt_pkg::CMD_INSERT;
    else if (p < 65) it.cmd = brt_pkg::CMD_REMOVE;
    else if (p < 95) it.cmd = brt_pkg::CMD_LOOKUP;
    else it.cmd = brt_pkg::CMD_NONE;
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_data_o.status), -1);
        end else begin
          if (out_data_o.hop_out != pending_results[0].hop_out)
            report_mismatch("hop_out", int'(out_data_o.hop_out),
                            int'(pending_results[0].hop_out));
          if (out_data_o.status != pending_results[0].status)
            report_mismatch("status", int'(out_data_o.status),
                            int'(pending_results[0].status));
          void'(pending_results.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: watchdog expired");
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    brt_pkg::out_item_t none;
    brt_pkg::in_item_t it;
    int mode;
    none = '0;
    trie_reset();
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'hFFFF, 5'd16, 8'd0), 1, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_REMOVE, 16'h8000, 5'd1, 8'd0), 1, 8'd0, brt_pkg::ST_NO_PATH);
    add_row(mk(brt_pkg::CMD_INSERT, 16'h0000, 5'd0, 8'd255), 1, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'h1234, 5'd16, 8'd0), 1, 8'd255, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_INSERT, 16'hFFFF, 5'd31, 8'd1), 1, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_INSERT, 16'hF000, 5'd4, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_INSERT, 16'hA000, 5'd3, 8'd77), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'hAFFF, 5'd16, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'hFFFF, 5'd20, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'hF0FF, 5'd16, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_NONE, 16'hFFFF, 5'd31, 8'd255), 1, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_REMOVE, 16'hF000, 5'd4, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_REMOVE, 16'hFFFF, 5'd16, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'hFFFF, 5'd16, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_REMOVE, 16'h0000, 5'd0, 8'd0), 1, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_LOOKUP, 16'h0000, 5'd0, 8'd0), 1, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_REMOVE, 16'hA000, 5'd3, 8'd0), 0, 8'd0, brt_pkg::ST_DONE);
    add_row(mk(brt_pkg::CMD_REMOVE, 16'hA000, 5'd3, 8'd0), 1, 8'd0, brt_pkg::ST_NO_PATH);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k]) send(directed[k].item, directed[k].typed, directed[k].want);
    // fill the pool to force full, then wait until all results are back
    for (int k = 0; k < 30; k++)
      send(mk(brt_pkg::CMD_INSERT, 16'($urandom()), 5'd16, 8'($urandom())), 0, none);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    for (int k = 0; k < 400; k++) begin
      mode = (k % 100 < 50) ? 1 : 0;
      it = rand_item(mode);
      send(it, 0, none);
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("tb: %0d inserts, %0d removes, %0d lookups; %0d pool-full, %0d missing-path",
             n_ins, n_rem, n_look, n_full, n_nopath);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/brt_pkg.sv
rtl/core/brt_node_mem.sv
rtl/core/brt_free_stack.sv
rtl/core/brt_ctrl.sv
rtl/core/binary_trie_route_table.sv
test/tb.sv
